// ----- design/websocket_frame_deframer_core_defines.svh -----
// Assertion macros used by the result queue of the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define WSFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsfd assertion failed");

// Check that cons holds in the cycle after ante.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsfd assertion failed");

`endif

// ----- design/wsfd_pkg.sv -----
// Shared types and constants of the WebSocket frame deframer.
`default_nettype none

package wsfd_pkg;

  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;
  localparam logic [6:0]  LEN_EXT16     = 7'd126;
  localparam logic [6:0]  LEN_EXT64     = 7'd127;
  localparam logic [2:0]  EXT16_BYTES   = 3'd1;
  localparam logic [2:0]  EXT64_BYTES   = 3'd7;
  localparam logic [2:0]  MASK_BYTES    = 3'd3;

  typedef enum logic [2:0] {
    PHASE_HDR0    = 3'd0,
    PHASE_HDR1    = 3'd1,
    PHASE_EXTLEN  = 3'd2,
    PHASE_MASK    = 3'd3,
    PHASE_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_TOO_LONG = 2'd2
  } kind_e;

  // One classified result waiting to be unmasked and delivered.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic [3:0]  opcode;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ----- design/wsfd_parser.sv -----
// Front part: header parser that classifies each stream byte.
`default_nettype none

module wsfd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [15:0]    cfg_data_i,
  input  logic           accept_i,
  input  logic [7:0]     stream_byte_i,
  output logic           res_valid_o,
  output wsfd_pkg::res_t res_o
);
  import wsfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [63:0] rem_len_q, rem_len_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic        mask_en_q, mask_en_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [1:0]  mask_idx_q, mask_idx_d;
  logic        skip_q, skip_d;
  logic [15:0] max_len_q;

  logic        fin;
  logic        too_long;
  logic [63:0] rem_dec;
  logic        done;
  logic [7:0]  key_byte;

  assign rem_dec  = (rem_len_q != 64'd0) ? (rem_len_q - 64'd1) : rem_len_q;
  assign done     = (rem_dec == 64'd0);
  assign key_byte = mask_key_q[{~mask_idx_q, 3'b000} +: 8];

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    rem_len_d   = rem_len_q;
    mask_key_d  = mask_key_q;
    mask_en_d   = mask_en_q;
    opcode_d    = opcode_q;
    mask_idx_d  = mask_idx_q;
    skip_d      = skip_q;
    fin         = 1'b0;
    too_long    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_BYTE, data: 8'd0, key: 8'd0, opcode: opcode_q, last: 1'b0};

    if (accept_i) begin
      case (phase_q)
        PHASE_HDR1: begin
          mask_en_d  = stream_byte_i[7];
          mask_key_d = 32'd0;
          rem_len_d  = 64'd0;
          if (stream_byte_i[6:0] == LEN_EXT16) begin
            phase_d   = PHASE_EXTLEN;
            hdr_cnt_d = EXT16_BYTES;
          end else if (stream_byte_i[6:0] == LEN_EXT64) begin
            phase_d   = PHASE_EXTLEN;
            hdr_cnt_d = EXT64_BYTES;
          end else begin
            rem_len_d = {57'd0, stream_byte_i[6:0]};
            if (stream_byte_i[7]) begin
              phase_d   = PHASE_MASK;
              hdr_cnt_d = MASK_BYTES;
            end else begin
              fin = 1'b1;
            end
          end
        end
        PHASE_EXTLEN: begin
          rem_len_d = {rem_len_q[55:0], stream_byte_i};
          if (hdr_cnt_q == 3'd0) begin
            if (mask_en_q) begin
              phase_d   = PHASE_MASK;
              hdr_cnt_d = MASK_BYTES;
            end else begin
              fin = 1'b1;
            end
          end else begin
            hdr_cnt_d = hdr_cnt_q - 3'd1;
          end
        end
        PHASE_MASK: begin
          mask_key_d = {mask_key_q[23:0], stream_byte_i};
          if (hdr_cnt_q == 3'd0) begin
            fin = 1'b1;
          end else begin
            hdr_cnt_d = hdr_cnt_q - 3'd1;
          end
        end
        PHASE_PAYLOAD: begin
          rem_len_d = rem_dec;
          if (done) begin
            phase_d = PHASE_HDR0;
          end
          if (skip_q) begin
            if (done) begin
              skip_d = 1'b0;
            end
          end else begin
            mask_idx_d  = mask_idx_q + 2'd1;
            res_valid_o = 1'b1;
            res_o.data  = stream_byte_i;
            res_o.key   = key_byte;
            res_o.last  = done;
          end
        end
        default: begin
          opcode_d = stream_byte_i[3:0];
          phase_d  = PHASE_HDR1;
        end
      endcase

      // Header complete: check length against the limit.
      if (fin) begin
        mask_idx_d  = 2'd0;
        res_o.last  = 1'b1;
        too_long    = (|rem_len_d[63:16]) || (rem_len_d[15:0] > max_len_q);
        if (too_long) begin
          skip_d      = 1'b1;
          phase_d     = PHASE_PAYLOAD;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_TOO_LONG;
        end else begin
          skip_d = 1'b0;
          if (rem_len_d == 64'd0) begin
            phase_d     = PHASE_HDR0;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_EMPTY;
          end else begin
            phase_d = PHASE_PAYLOAD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PHASE_HDR0;
      hdr_cnt_q  <= 3'd0;
      rem_len_q  <= 64'd0;
      mask_key_q <= 32'd0;
      mask_en_q  <= 1'b0;
      opcode_q   <= 4'd0;
      mask_idx_q <= 2'd0;
      skip_q     <= 1'b0;
      max_len_q  <= MAX_LEN_RESET;
    end else begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      rem_len_q  <= rem_len_d;
      mask_key_q <= mask_key_d;
      mask_en_q  <= mask_en_d;
      opcode_q   <= opcode_d;
      mask_idx_q <= mask_idx_d;
      skip_q     <= skip_d;
      if (cfg_valid_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/wsfd_fifo.sv -----
// Short result queue between the parser and the output stage.
`default_nettype none

module wsfd_fifo #(
  parameter int unsigned Depth = wsfd_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  wsfd_pkg::res_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output wsfd_pkg::res_t rd_data_o,
  output logic           empty_o
);
  import wsfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_en_i && rd_en_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`include "websocket_frame_deframer_core_defines.svh"

  `WSFD_ASSERT_SAME(a_no_overflow, clk_i, rst_ni, wr_en_i && !rd_en_i, !full_o)
  `WSFD_ASSERT_SAME(a_no_underflow, clk_i, rst_ni, rd_en_i, !empty_o)
  `WSFD_ASSERT_NEXT(a_write_lands, clk_i, rst_ni, wr_en_i && !rd_en_i, !empty_o)

endmodule

`default_nettype wire

// ----- design/wsfd_emit.sv -----
// Back part: unmask the queued result and hold it for the consumer.
`default_nettype none

module wsfd_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  wsfd_pkg::res_t q_data_i,
  output logic           q_rd_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [1:0]     kind_o,
  output logic [7:0]     payload_byte_o,
  output logic [3:0]     frame_opcode_o,
  output logic           last_o
);
  import wsfd_pkg::*;

  logic       valid_q;
  kind_e      kind_q;
  logic [7:0] byte_q;
  logic [3:0] opcode_q;
  logic       last_q;

  // Refill when the register is free or is being taken this cycle.
  assign q_rd_o = !q_empty_i && (!valid_q || pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      kind_q   <= q_data_i.kind;
      byte_q   <= q_data_i.data ^ q_data_i.key;
      opcode_q <= q_data_i.opcode;
      last_q   <= q_data_i.last;
    end
  end

  assign empty_o        = !valid_q;
  assign kind_o         = kind_q;
  assign payload_byte_o = byte_q;
  assign frame_opcode_o = opcode_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// ----- design/websocket_frame_deframer_core.sv -----
// Top level of the WebSocket frame deframer: parser, result queue, output stage.
//
//   Channel   Handshake           Payload
//   input     push / full         stream_byte_i
//   result    empty / pop         kind_o, payload_byte_o, frame_opcode_o, last_o
//   config    cfg_valid_i / _o    cfg_max_payload_len_i
//
// One stream byte is taken every cycle while full is low; the header parser
// does its whole job for a byte in that cycle, the 64-bit length decrement
// and limit compare being the longest path. A result is queued, then held in
// the output register. No clearing pass: everything is ready after reset.
// The queue lets the parser run on while the consumer stalls; full rises only
// once QueueDepth results and the output register are all waiting.
`default_nettype none

module websocket_frame_deframer_core #(
  parameter int unsigned QueueDepth = wsfd_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        push,
  output logic        full,
  input  logic [7:0]  stream_byte_i,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [3:0]  frame_opcode_o,
  output logic        last_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_max_payload_len_i
);
  import wsfd_pkg::*;

  logic accept;
  logic res_valid;
  res_t res;
  logic q_full;
  logic q_empty;
  logic q_rd;
  res_t q_head;

  // Take a byte whenever the queue has room for a possible result.
  assign accept      = push && !q_full;
  assign full        = q_full;
  assign cfg_ready_o = 1'b1;

  // Front: parse headers, classify payload bytes.
  wsfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_max_payload_len_i),
    .accept_i      (accept),
    .stream_byte_i (stream_byte_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Queue between parser and output stage.
  wsfd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .full_o    (q_full),
    .rd_en_i   (q_rd),
    .rd_data_o (q_head),
    .empty_o   (q_empty)
  );

  // Back: apply the mask key and present the oldest result.
  wsfd_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_head),
    .q_rd_o         (q_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_opcode_o (frame_opcode_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the WebSocket frame deframer core.
`timescale 1ns / 100ps

module testbench;
  import wsfd_pkg::*;

  localparam int unsigned IDLE_PCT   = 31;
  localparam int unsigned RAND_ITEMS = 1380;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned SETTLE_CYCLES = 3;

  // One result as it leaves the block.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } frame_result_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_e;

  // One step of the directed script: a stream byte or a limit write.
  typedef struct {
    row_e          op;
    logic [15:0]   value;
    bit            typed;
    frame_result_t want;
  } stim_row_t;

  localparam frame_result_t NO_RES = '{KIND_BYTE, 8'h00, 4'h0, 1'b0};
  localparam int unsigned SCRIPT_ROWS = 28;

  // Directed script. Rows with a typed result check that value directly;
  // all other rows are checked against the deframing predictor.
  stim_row_t script [SCRIPT_ROWS] = '{
    // empty unmasked frame, opcode 0
    '{ROW_BYTE, 16'h0080, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b1, '{KIND_EMPTY, 8'h00, 4'h0, 1'b1}},
    // opcode 15 with reserved bits set, one unmasked byte passes unchanged
    '{ROW_BYTE, 16'h00FF, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0001, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00FF, 1'b1, '{KIND_BYTE, 8'hFF, 4'hF, 1'b1}},
    // masked single byte
    '{ROW_BYTE, 16'h0002, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0081, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00A5, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h005A, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00FF, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h000F, 1'b0, NO_RES},
    // two-byte extended length of one
    '{ROW_BYTE, 16'h0001, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h007E, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0001, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b1, '{KIND_BYTE, 8'h00, 4'h1, 1'b1}},
    // limit of zero: any payload is too long and gets skipped
    '{ROW_CFG,  16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h000A, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0001, 1'b1, '{KIND_TOO_LONG, 8'h00, 4'hA, 1'b1}},
    '{ROW_BYTE, 16'h0033, 1'b0, NO_RES},
    // masked empty frame still fits a zero limit
    '{ROW_BYTE, 16'h007B, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0080, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00DE, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00AD, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00BE, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00EF, 1'b1, '{KIND_EMPTY, 8'h00, 4'hB, 1'b1}},
    '{ROW_CFG,  16'hFFFF, 1'b0, NO_RES}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  stream_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [3:0]  frame_opcode;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_max_len = 16'h0000;

  // Predictor copy of the parser state and the limit register.
  phase_e      hdr_phase = PHASE_HDR0;
  logic [2:0]  hdr_left = '0;
  logic [63:0] len_left = '0;
  logic [31:0] mask_key = '0;
  logic        masked = 1'b0;
  logic [3:0]  opcode = '0;
  logic [1:0]  key_idx = '0;
  logic        dropping = 1'b0;
  logic [15:0] max_len = MAX_LEN_RESET;

  frame_result_t results_due[$];
  frame_result_t head;
  bit            failed = 1'b0;
  bit            calm = 1'b0;
  bit            rx_hold_req = 1'b0;
  int unsigned   items = 0;

  websocket_frame_deframer_core dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .push                  (push),
    .full                  (full),
    .stream_byte_i         (stream_byte),
    .empty                 (empty),
    .pop                   (pop),
    .kind_o                (kind),
    .payload_byte_o        (payload_byte),
    .frame_opcode_o        (frame_opcode),
    .last_o                (last),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_max_payload_len_i (cfg_max_len)
  );

  always #5 clk = ~clk;

  // Header done: classify the frame as too long, empty or carrying payload.
  task automatic close_header(output bit got, output frame_result_t r);
    key_idx = '0;
    if (len_left > 64'(max_len)) begin
      dropping = 1'b1;
      hdr_phase = PHASE_PAYLOAD;
      got = 1'b1;
      r = '{KIND_TOO_LONG, 8'h00, opcode, 1'b1};
    end else begin
      dropping = 1'b0;
      if (len_left == 0) begin
        hdr_phase = PHASE_HDR0;
        got = 1'b1;
        r = '{KIND_EMPTY, 8'h00, opcode, 1'b1};
      end else begin
        hdr_phase = PHASE_PAYLOAD;
      end
    end
  endtask

  task automatic close_length(output bit got, output frame_result_t r);
    if (masked) begin
      hdr_phase = PHASE_MASK;
      hdr_left = MASK_BYTES;
    end else begin
      close_header(got, r);
    end
  endtask

  // Advance the predictor by one stream byte and give the result it causes.
  task automatic deframe_byte(input logic [7:0] b, output bit got,
                              output frame_result_t r);
    logic [7:0] k;
    got = 1'b0;
    r = NO_RES;
    case (hdr_phase)
      PHASE_HDR1: begin
        masked = b[7];
        mask_key = '0;
        len_left = '0;
        if (b[6:0] == LEN_EXT16) begin
          hdr_phase = PHASE_EXTLEN;
          hdr_left = EXT16_BYTES;
        end else if (b[6:0] == LEN_EXT64) begin
          hdr_phase = PHASE_EXTLEN;
          hdr_left = EXT64_BYTES;
        end else begin
          len_left = 64'(b[6:0]);
          close_length(got, r);
        end
      end
      PHASE_EXTLEN: begin
        len_left = {len_left[55:0], b};
        if (hdr_left == 0) close_length(got, r);
        else hdr_left = hdr_left - 3'd1;
      end
      PHASE_MASK: begin
        mask_key = {mask_key[23:0], b};
        if (hdr_left == 0) close_header(got, r);
        else hdr_left = hdr_left - 3'd1;
      end
      PHASE_PAYLOAD: begin
        if (len_left != 0) len_left = len_left - 64'd1;
        if (len_left == 0) hdr_phase = PHASE_HDR0;
        if (dropping) begin
          if (len_left == 0) dropping = 1'b0;
        end else begin
          // rotate through the key, most significant byte first
          k = 8'(mask_key >> (24 - 8 * int'(key_idx)));
          key_idx = key_idx + 2'd1;
          got = 1'b1;
          r = '{KIND_BYTE, b ^ k, opcode, len_left == 0};
        end
      end
      default: begin
        opcode = b[3:0];
        hdr_phase = PHASE_HDR1;
      end
    endcase
  endtask

  // Offer one byte, idling at random first; called and returns at a falling edge.
  task automatic offer_byte(input logic [7:0] b, input bit typed,
                            input frame_result_t want);
    bit            got;
    frame_result_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (full);
    items++;
    deframe_byte(b, got, r);
    if (typed) results_due.push_back(want);
    else if (got) results_due.push_back(r);
    @(negedge clk);
  endtask

  // Stop sending and wait for every outstanding result, then let the parser settle.
  task automatic drain_results();
    push <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_limit(input logic [15:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_max_len <= v;
    do @(posedge clk); while (!cfg_ready);
    max_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send one well-formed frame with random header flags, length form and content.
  // A non-negative mid_limit is written after the second header byte.
  task automatic send_frame(input logic [3:0] op, input int unsigned len,
                            input bit use_mask, input int mid_limit);
    logic [63:0] len64;
    logic [31:0] key;
    int unsigned form;
    logic [6:0]  len7;
    len64 = 64'(len);
    key = $urandom;
    if (len <= 125) form = $urandom_range(2);
    else form = $urandom_range(2, 1);
    len7 = (form == 0) ? 7'(len) : (form == 1) ? LEN_EXT16 : LEN_EXT64;
    offer_byte({4'($urandom), op}, 1'b0, NO_RES);
    offer_byte({use_mask, len7}, 1'b0, NO_RES);
    if (mid_limit >= 0) program_limit(16'(mid_limit));
    if (form == 1)
      for (int i = 1; i >= 0; i--) offer_byte(len64[8*i +: 8], 1'b0, NO_RES);
    if (form == 2)
      for (int i = 7; i >= 0; i--) offer_byte(len64[8*i +: 8], 1'b0, NO_RES);
    if (use_mask)
      for (int i = 3; i >= 0; i--) offer_byte(key[8*i +: 8], 1'b0, NO_RES);
    for (int unsigned i = 0; i < len; i++) offer_byte(8'($urandom), 1'b0, NO_RES);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Consumer side: idle at random, or hold off for a fixed stretch on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare every delivered result with the oldest one due.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0d, byte %0h, opcode %0h, last %0b",
               kind, payload_byte, frame_opcode, last);
        failed = 1'b1;
      end else begin
        head = results_due.pop_front();
        check_field("kind", 8'(head.kind), 8'(kind));
        check_field("payload_byte", head.data, payload_byte);
        check_field("frame_opcode", 8'(head.opcode), 8'(frame_opcode));
        check_field("last", 8'(head.last), 8'(last));
      end
    end
  end

  initial begin
    int unsigned phase_no;
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    logic [15:0] new_limit;
    phase_no = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (script[i].op == ROW_CFG) program_limit(script[i].value);
      else offer_byte(script[i].value[7:0], script[i].typed, script[i].want);
    end

    // Random phases, each under its own limit setting.
    items = 0;
    while (items < RAND_ITEMS) begin
      case (phase_no % 8)
        0: new_limit = MAX_LEN_RESET;
        1: new_limit = 16'd0;
        2: new_limit = 16'd7;
        3: new_limit = 16'hFFFF;
        4: new_limit = 16'($urandom_range(300));
        5: new_limit = 16'd1;
        6: new_limit = 16'($urandom_range(16'hFFFF));
        default: new_limit = 16'd40;
      endcase
      calm = (phase_no == 2);
      program_limit(new_limit);
      // hold the consumer off while a long frame streams in, so the queue fills
      if (phase_no == 3) begin
        rx_hold_req = 1'b1;
        send_frame(4'h2, 48, 1'b1, -1);
      end
      // change the limit between header bytes of a frame
      if (phase_no == 5) send_frame(4'($urandom), 6, 1'b1, 200);
      start = items;
      while (items - start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(12);
        else if (pick < 88) len = $urandom_range(130, 13);
        else if (pick < 95 && max_len <= 600) len = max_len + $urandom_range(3);
        else if (pick < 95) len = $urandom_range(12);
        else len = $urandom_range(600, 131);
        send_frame(4'($urandom), len, $urandom_range(1), -1);
        if ($urandom_range(19) == 0) drain_results();
      end
      phase_no++;
    end
    calm = 1'b0;

    // Eight-byte length with bit 63 set: always too long, and the stream stays
    // in skipping for the rest of the run, so this frame comes last.
    offer_byte(8'h81, 1'b0, NO_RES);
    offer_byte({1'b1, LEN_EXT64}, 1'b0, NO_RES);
    for (int i = 7; i >= 0; i--)
      offer_byte(8'(64'h8000_0000_0000_0003 >> (8 * i)), 1'b0, NO_RES);
    repeat (4 + 24) offer_byte(8'($urandom), 1'b0, NO_RES);

    drain_results();
    repeat (20) @(negedge clk);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
